// ===== src/mdsd_pkg.sv =====
// Shared types and constants for the modular synthetic division block.
package mdsd_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int DATA_W        = 64;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT    = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] coefficient;
		logic              final_coeff;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              is_remainder;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROOT,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic idle;
		logic load_root;
		logic step;
		logic root_pass;
		logic pass_end;
		logic load_out;
	} ctl_t;

endpackage

// ===== src/modular_synthetic_division.sv =====
// Top level: Horner synthetic division by (x - root) modulo a runtime modulus.
//
// Channels: in (in_valid/in_ready/in_data) takes one coefficient per beat,
// highest degree first, final_coeff set on the constant term. out
// (out_valid/out_ready/out_data) gives one beat per input: a quotient
// coefficient, or the remainder with is_remainder set. cfg (cfg_valid/
// cfg_ready/cfg_index/cfg_data) writes modulus (index 0) or root (index 1).
// Each input beat runs through one shared modular shift-add unit
// (2r + coeff bit + acc bit * root, one bit per cycle), then loads the
// output register; no new beat is taken until that load has happened.
// Each configuration write is followed by a pass that reduces root
// under the current modulus; inputs and further writes wait meanwhile.
// Reset sets modulus 1, root 0 and awaits a leading coefficient.
// A stalled result holds in the output register; the block then waits with
// its next result until the register empties.
module modular_synthetic_division #(
	parameter int WORD_BITS = mdsd_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mdsd_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mdsd_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mdsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mdsd_pkg::DATA_W-1:0]       cfg_data
);

	localparam int W  = WORD_BITS;
	localparam int DW = mdsd_pkg::DATA_W;

	mdsd_pkg::ctl_t      ctl;
	mdsd_pkg::out_item_t out_q;
	logic [W-1:0]        modulus_q;
	logic [W-1:0]        root_q;
	logic [W-1:0]        root_red_q;
	logic [W-1:0]        acc_q;
	logic                in_prog_q;
	logic                out_valid_q;
	logic [W-1:0]        coef_sh_q;
	logic [W-1:0]        acc_sh_q;
	logic [W-1:0]        r_q;
	logic                last_q;
	logic [W-1:0]        r_next;
	logic                cfg_fire;
	logic                in_fire;
	logic                out_fire;

	assign cfg_ready = ctl.idle;
	assign in_ready  = ctl.idle && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	mdsd_ctrl #(.W(W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_fire (cfg_fire),
		.in_fire  (in_fire),
		.out_free (!out_valid_q || out_ready),
		.ctl      (ctl)
	);

	mdsd_modstep #(.W(W)) u_step (
		.acc_r   (r_q),
		.cbit    (coef_sh_q[W-1]),
		.abit    (acc_sh_q[W-1]),
		.addend  (root_red_q),
		.modulus (modulus_q),
		.r_next  (r_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= W'(1);
			root_q      <= '0;
			root_red_q  <= '0;
			in_prog_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					mdsd_pkg::REG_MODULUS: modulus_q <= cfg_data[W-1:0];
					mdsd_pkg::REG_ROOT:    root_q    <= cfg_data[W-1:0];
					default:               root_q    <= root_q;
				endcase
			end
			if (ctl.root_pass && ctl.pass_end) begin
				root_red_q <= r_next;
			end
			if (ctl.load_out) begin
				in_prog_q   <= !last_q;
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			coef_sh_q <= in_data.coefficient[W-1:0];
			acc_sh_q  <= in_prog_q ? acc_q : '0;
			r_q       <= '0;
			last_q    <= in_data.final_coeff;
		end else if (ctl.load_root) begin
			coef_sh_q <= root_q;
			acc_sh_q  <= '0;
			r_q       <= '0;
		end else if (ctl.step) begin
			coef_sh_q <= {coef_sh_q[W-2:0], 1'b0};
			acc_sh_q  <= {acc_sh_q[W-2:0], 1'b0};
			r_q       <= r_next;
		end
		if (ctl.load_out) begin
			acc_q              <= r_q;
			out_q.value        <= DW'(r_q);
			out_q.is_remainder <= last_q;
		end
	end

`ifndef SYNTHESIS
	a_r_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && !ctl.root_pass) |-> ({1'b0, r_q} < {(modulus_q == '0), modulus_q}))
		else $error("running value not reduced below modulus");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (!in_ready && !cfg_ready))
		else $error("ready while an item is in work");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_prog_q) |-> (out_valid_q && out_q.is_remainder))
		else $error("run ended without a remainder beat");
`endif

endmodule

// ===== src/mdsd_modstep.sv =====
// Shared modular step unit: r' = (2r + cbit + abit*addend) mod n, n = 0 meaning 2^W.
module mdsd_modstep #(
	parameter int W = mdsd_pkg::WORD_BITS_DEF
) (
	input  logic [W-1:0] acc_r,
	input  logic         cbit,
	input  logic         abit,
	input  logic [W-1:0] addend,
	input  logic [W-1:0] modulus,
	output logic [W-1:0] r_next
);

	logic [W:0]   n_e;
	logic [W+1:0] n1;
	logic [W+1:0] n2;
	logic [W+1:0] sum;
	logic [W+1:0] dif1;
	logic [W+1:0] dif2;
	logic [W+1:0] res;

	always_comb begin
		n_e  = {(modulus == '0), modulus};
		n1   = {1'b0, n_e};
		n2   = {n_e, 1'b0};
		sum  = {1'b0, acc_r, cbit} + {2'b00, (abit ? addend : '0)};
		dif1 = sum - n1;
		dif2 = sum - n2;
		priority if (sum >= n2) begin
			res = dif2;
		end else if (sum >= n1) begin
			res = dif1;
		end else begin
			res = sum;
		end
		r_next = res[W-1:0];
	end

endmodule

// ===== src/mdsd_ctrl.sv =====
// Sequencer: bit counter and pass control for the shared modular step unit.
module mdsd_ctrl #(
	parameter int W = mdsd_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_fire,
	input  logic          in_fire,
	input  logic          out_free,
	output mdsd_pkg::ctl_t ctl
);

	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	mdsd_pkg::state_t state_q;
	mdsd_pkg::state_t state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdsd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (ctl.step && !ctl.pass_end) ? cnt_q + 1'b1 : '0;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			mdsd_pkg::ST_IDLE: begin
				ctl.idle = 1'b1;
				if (cfg_fire) begin
					state_d = mdsd_pkg::ST_PREP;
				end else if (in_fire) begin
					state_d = mdsd_pkg::ST_STEP;
				end
			end
			mdsd_pkg::ST_PREP: begin
				ctl.load_root = 1'b1;
				state_d       = mdsd_pkg::ST_ROOT;
			end
			mdsd_pkg::ST_ROOT: begin
				ctl.step      = 1'b1;
				ctl.root_pass = 1'b1;
				ctl.pass_end  = (cnt_q == CNT_LAST);
				if (ctl.pass_end) begin
					state_d = mdsd_pkg::ST_IDLE;
				end
			end
			mdsd_pkg::ST_STEP: begin
				ctl.step     = 1'b1;
				ctl.pass_end = (cnt_q == CNT_LAST);
				if (ctl.pass_end) begin
					state_d = mdsd_pkg::ST_DONE;
				end
			end
			mdsd_pkg::ST_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = mdsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdsd_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_pass_len: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && !ctl.pass_end) |=> (ctl.step && cnt_q == $past(cnt_q) + 1'b1))
		else $error("bit counter skipped during a pass");
`endif

endmodule
